// ===== hdl/rmsd_pkg.sv =====
// Shared constants for the windowed RMS silence run detector.
`timescale 1ns / 1ps
`default_nettype none

package rmsd_pkg;

  // Accumulator widths
  localparam int unsigned ENERGY_BITS = 64;
  localparam int unsigned COUNT_BITS  = 48;
  localparam int unsigned WCOUNT_BITS = 20;
  localparam int unsigned SQ_BITS     = 31;   // one square in Q1.30

  // Score arithmetic
  localparam logic [15:0] ONE_Q16         = 16'hFFFF;
  localparam logic [12:0] DEPTH_RANGE_Q8  = 13'd7680;   // 30 dB in Q8.8
  localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283; // 10*log10(2) scaled by 2^16
  localparam logic [22:0] FULL_SCALE_LOG2 = 23'(30 << 16);

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_WINDOW_FRAMES = 3'd1,
    REG_MIN_SILENCE   = 3'd2,
    REG_THRESH_POWER  = 3'd3,
    REG_THRESH_DB     = 3'd4
  } reg_index_e;

endpackage

`default_nettype wire

// ===== hdl/rmsd_front.sv =====
// Front end: squares samples, closes windows, tracks silent runs, hands closed runs to the queue.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_front
  import rmsd_pkg::*;
#(
  parameter int unsigned FRAME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned MAX_CHANNELS = 8,
  localparam int unsigned JOB_BITS    = 2 * FRAME_BITS + ENERGY_BITS + COUNT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [3:0]             channel_count_i,
  input  wire logic [15:0]            window_frames_i,
  input  wire logic [30:0]            threshold_power_i,
  input  wire logic                   in_valid_i,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic                   in_last_i,
  output logic                        push_o,
  output logic [JOB_BITS-1:0]         job_o
);

  localparam int unsigned SQ_RAW = 2 * (SAMPLE_BITS - 1);
  localparam int unsigned SHR    = (SQ_RAW >= 30) ? SQ_RAW - 30 : 0;
  localparam int unsigned SHL    = (SQ_RAW < 30) ? 30 - SQ_RAW : 0;
  localparam int unsigned CIW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned PRODW  = 31 + WCOUNT_BITS;
  localparam logic [WCOUNT_BITS-1:0] WCOUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

  // Stage A: square
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] mag_sq;
  logic [63:0]              sq_wide;
  logic                     a_valid_q;
  logic [SQ_BITS-1:0]       a_sq_q;
  logic                     a_last_q;

  assign mag     = in_sample_i[SAMPLE_BITS-1] ? (~in_sample_i + 1'b1) : in_sample_i;
  assign mag_sq  = mag * mag;
  assign sq_wide = (64'(mag_sq) >> SHR) << SHL;

  // Stage B: frame and window counters
  logic [CIW-1:0]         ci_q, ci_d, ci_inc, ch_eff;
  logic [FRAME_BITS-1:0]  fc_q, fc_d, fc_inc, ws_q, ws_d, span;
  logic [ENERGY_BITS-1:0] we_q, we_d, en_new;
  logic [WCOUNT_BITS-1:0] wc_q, wc_d, wc_new;
  logic [15:0]            wf_eff;
  logic                   frame_end, close;

  // Stage C: threshold product
  logic                   c_valid_q, c_last_q;
  logic [ENERGY_BITS-1:0] c_en_q;
  logic [WCOUNT_BITS-1:0] c_cnt_q;
  logic [FRAME_BITS-1:0]  c_ws_q, c_fc_q;

  // Stage D: run tracking
  logic                   d_valid_q, d_last_q;
  logic [ENERGY_BITS-1:0] d_en_q;
  logic [WCOUNT_BITS-1:0] d_cnt_q;
  logic [FRAME_BITS-1:0]  d_ws_q, d_fc_q;
  logic [PRODW-1:0]       d_lim_q;

  logic                   in_run_q, in_run_d;
  logic [FRAME_BITS-1:0]  rs_q, rs_d, re_q, re_d;
  logic [ENERGY_BITS-1:0] ren_q, ren_d, ren_base, ren_new;
  logic [COUNT_BITS-1:0]  rc_q, rc_d, rc_base, rc_new;
  logic [ENERGY_BITS:0]   ren_sum;
  logic [COUNT_BITS:0]    rc_sum;
  logic [FRAME_BITS-1:0]  st_new;
  logic                   silent;

  always_comb begin
    if (channel_count_i == 4'd0) begin
      ch_eff = CIW'(1);
    end else if ({1'b0, channel_count_i} > 5'(MAX_CHANNELS)) begin
      ch_eff = CIW'(MAX_CHANNELS);
    end else begin
      ch_eff = CIW'(channel_count_i);
    end
    wf_eff    = (window_frames_i == 16'd0) ? 16'd1 : window_frames_i;
    en_new    = we_q + ENERGY_BITS'(a_sq_q);
    wc_new    = (wc_q < WCOUNT_MAX) ? wc_q + 1'b1 : wc_q;
    ci_inc    = ci_q + 1'b1;
    fc_inc    = fc_q + 1'b1;
    span      = fc_inc - ws_q;
    frame_end = (ci_inc >= ch_eff) || a_last_q;
    close     = frame_end && ((span >= FRAME_BITS'(wf_eff)) || a_last_q);

    ci_d = ci_q;
    fc_d = fc_q;
    ws_d = ws_q;
    we_d = we_q;
    wc_d = wc_q;
    if (a_valid_q) begin
      we_d = en_new;
      wc_d = wc_new;
      ci_d = ci_inc;
      if (frame_end) begin
        ci_d = '0;
        fc_d = fc_inc;
      end
      if (close) begin
        ws_d = fc_inc;
        we_d = '0;
        wc_d = '0;
      end
      // end of buffer rewinds the frame position
      if (a_last_q) begin
        fc_d = '0;
        ws_d = '0;
        ci_d = '0;
      end
    end
  end

  always_comb begin
    silent   = ENERGY_BITS'(d_lim_q) > d_en_q;
    ren_base = in_run_q ? ren_q : '0;
    rc_base  = in_run_q ? rc_q : '0;
    st_new   = in_run_q ? rs_q : d_ws_q;
    ren_sum  = {1'b0, ren_base} + {1'b0, d_en_q};
    ren_new  = ren_sum[ENERGY_BITS] ? '1 : ren_sum[ENERGY_BITS-1:0];
    rc_sum   = {1'b0, rc_base} + (COUNT_BITS + 1)'(d_cnt_q);
    rc_new   = (rc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : rc_sum[COUNT_BITS-1:0];

    in_run_d = in_run_q;
    rs_d     = rs_q;
    re_d     = re_q;
    ren_d    = ren_q;
    rc_d     = rc_q;
    push_o   = 1'b0;
    job_o    = {rc_q, ren_q, re_q, rs_q};
    if (d_valid_q) begin
      if (silent) begin
        in_run_d = 1'b1;
        rs_d     = st_new;
        re_d     = d_fc_q;
        ren_d    = ren_new;
        rc_d     = rc_new;
        if (d_last_q) begin
          push_o   = 1'b1;
          in_run_d = 1'b0;
          job_o    = {rc_new, ren_new, d_fc_q, st_new};
        end
      end else if (in_run_q) begin
        push_o   = 1'b1;
        in_run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      ci_q      <= '0;
      fc_q      <= '0;
      ws_q      <= '0;
      we_q      <= '0;
      wc_q      <= '0;
      in_run_q  <= 1'b0;
      rs_q      <= '0;
      re_q      <= '0;
      ren_q     <= '0;
      rc_q      <= '0;
    end else begin
      a_valid_q <= in_valid_i;
      c_valid_q <= a_valid_q && close;
      d_valid_q <= c_valid_q;
      ci_q      <= ci_d;
      fc_q      <= fc_d;
      ws_q      <= ws_d;
      we_q      <= we_d;
      wc_q      <= wc_d;
      in_run_q  <= in_run_d;
      rs_q      <= rs_d;
      re_q      <= re_d;
      ren_q     <= ren_d;
      rc_q      <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      a_sq_q   <= sq_wide[SQ_BITS-1:0];
      a_last_q <= in_last_i;
    end
    c_en_q   <= en_new;
    c_cnt_q  <= wc_new;
    c_ws_q   <= ws_q;
    c_fc_q   <= fc_inc;
    c_last_q <= a_last_q;
    d_lim_q  <= threshold_power_i * c_cnt_q;
    d_en_q   <= c_en_q;
    d_cnt_q  <= c_cnt_q;
    d_ws_q   <= c_ws_q;
    d_fc_q   <= c_fc_q;
    d_last_q <= c_last_q;
  end

endmodule

`default_nettype wire

// ===== hdl/rmsd_queue.sv =====
// Small FIFO holding closed runs between the front end and the scoring back end.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o,
  output logic [AW:0]           level_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      level_q;
  logic             do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign valid_o = level_q != '0;
  assign data_o  = slot_q[rptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   level_q <= level_q + 1'b1;
        2'b01:   level_q <= level_q - 1'b1;
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmsd_back.sv =====
// Back end: drops runs below the minimum length, scores the rest (length and depth) and holds the result for transfer.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_back
  import rmsd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 40,
  localparam int unsigned JOB_BITS  = 2 * FRAME_BITS + ENERGY_BITS + COUNT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [23:0]           min_silence_i,
  input  wire logic [15:0]           threshold_db_i,
  input  wire logic                  job_valid_i,
  input  wire logic [JOB_BITS-1:0]   job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [FRAME_BITS-1:0]      out_start_o,
  output logic [FRAME_BITS-1:0]      out_end_o,
  output logic [15:0]                out_score_o
);

  // ceil(2^24 / 15): exact quotient by 15 for operands below 2^20
  localparam logic [20:0] RECIP_DIV15 = 21'd1118482;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_START_LOG, ST_NORM, ST_SQR, ST_GAIN, ST_BELOW, ST_RECIP,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [FRAME_BITS-1:0]  start_q, end_q, frames_q;
  logic [ENERGY_BITS-1:0] energy_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic [15:0]            len_q, dep_q, quo_q, lo_q, frac_q;
  logic [25:0]            rem_q;
  logic [24:0]            dvs_q;
  logic [4:0]             step_q;
  logic                   phase_q;
  logic [63:0]            x_q;
  logic [5:0]             k_q;
  logic [31:0]            m_q;
  logic [22:0]            lc_q;
  logic [21:0]            le_q;
  logic [40:0]            prod_q;
  logic [19:0]            dq_q;
  logic                   out_valid_q;
  logic [FRAME_BITS-1:0]  out_start_q, out_end_q;
  logic [15:0]            out_score_q;

  logic [23:0]            minf;
  logic [24:0]            two_min;
  logic [FRAME_BITS:0]    frames_x;
  logic [40:0]            len_n;
  logic [25:0]            rem2;
  logic                   ge;
  logic [15:0]            q_fin;
  logic [63:0]            x_n;
  logic [5:0]             k_n;
  logic [63:0]            m_sq;
  logic [32:0]            m_t;
  logic [15:0]            frac_n;
  logic [21:0]            log_v;
  logic [22:0]            g;
  logic [18:0]            below;
  logic [28:0]            dep_n;
  logic [40:0]            dep_prod;
  logic [16:0]            score_sum;

  assign pop_o       = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;
  assign out_score_o = out_score_q;

  always_comb begin
    minf      = (min_silence_i == 24'd0) ? 24'd1 : min_silence_i;
    two_min   = {minf, 1'b0};
    frames_x  = {1'b0, frames_q};
    len_n     = 25'(frames_q) * ONE_Q16;
    rem2      = {rem_q[24:0], lo_q[15]};
    ge        = rem2 >= {1'b0, dvs_q};
    q_fin     = {quo_q[14:0], ge};
    // one binary step of the leading-one search per cycle
    x_n = x_q;
    k_n = k_q;
    case (step_q[2:0])
      3'd0: if (x_q[63:32] == '0) begin x_n = x_q << 32; k_n = k_q - 6'd32; end
      3'd1: if (x_q[63:48] == '0) begin x_n = x_q << 16; k_n = k_q - 6'd16; end
      3'd2: if (x_q[63:56] == '0) begin x_n = x_q << 8;  k_n = k_q - 6'd8;  end
      3'd3: if (x_q[63:60] == '0) begin x_n = x_q << 4;  k_n = k_q - 6'd4;  end
      3'd4: if (x_q[63:62] == '0) begin x_n = x_q << 2;  k_n = k_q - 6'd2;  end
      3'd5: if (x_q[63] == 1'b0)  begin x_n = x_q << 1;  k_n = k_q - 6'd1;  end
      default: begin x_n = x_q; k_n = k_q; end
    endcase
    m_sq      = m_q * m_q;
    m_t       = m_sq[63:31];
    frac_n    = {frac_q[14:0], m_t[32]};
    log_v     = {k_q, frac_n};
    g         = (lc_q > {1'b0, le_q}) ? lc_q - {1'b0, le_q} : '0;
    below     = {2'b00, prod_q[40:24]} + {{3{threshold_db_i[15]}}, threshold_db_i};
    dep_n     = below[12:0] * ONE_Q16;
    // divide by 7680 as a shift by 9 and a reciprocal multiply for 15
    dep_prod  = dq_q * RECIP_DIV15;
    score_sum = {1'b0, len_q} + {1'b0, dep_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (frames_x < (FRAME_BITS + 1)'(minf)) begin
            state_q <= ST_IDLE;
          end else if (frames_x >= (FRAME_BITS + 1)'(two_min)) begin
            state_q <= ST_START_LOG;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == 5'd15) begin
            state_q <= ST_START_LOG;
          end
        end
        ST_START_LOG: begin
          if (energy_q == '0 || count_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (step_q == 5'd5) begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (step_q == 5'd15) begin
            state_q <= phase_q ? ST_GAIN : ST_NORM;
          end
        end
        ST_GAIN: state_q <= ST_BELOW;
        ST_BELOW: begin
          if (below[18] || below == '0 || below >= 19'(DEPTH_RANGE_Q8)) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_RECIP;
          end
        end
        ST_RECIP: state_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        {count_q, energy_q, end_q, start_q} <= job_i;
        frames_q <= job_i[2*FRAME_BITS-1:FRAME_BITS] - job_i[FRAME_BITS-1:0];
      end
      ST_CHECK: begin
        len_q  <= ONE_Q16;
        rem_q  <= {1'b0, len_n[40:16]};
        lo_q   <= len_n[15:0];
        dvs_q  <= two_min;
        quo_q  <= '0;
        step_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= ge ? rem2 - {1'b0, dvs_q} : rem2;
        quo_q  <= q_fin;
        lo_q   <= {lo_q[14:0], 1'b0};
        step_q <= step_q + 1'b1;
        if (step_q == 5'd15) begin
          len_q <= q_fin;
        end
      end
      ST_START_LOG: begin
        dep_q   <= ONE_Q16;
        x_q     <= 64'(count_q);
        k_q     <= 6'd63;
        step_q  <= '0;
        phase_q <= 1'b0;
      end
      ST_NORM: begin
        x_q    <= x_n;
        k_q    <= k_n;
        step_q <= step_q + 1'b1;
        if (step_q == 5'd5) begin
          m_q    <= x_n[63:32];
          frac_q <= '0;
          step_q <= '0;
        end
      end
      ST_SQR: begin
        // renormalize the square back into [2^31, 2^32)
        m_q    <= m_t[32] ? m_t[32:1] : m_t[31:0];
        frac_q <= frac_n;
        step_q <= step_q + 1'b1;
        if (step_q == 5'd15) begin
          if (!phase_q) begin
            lc_q    <= 23'(log_v) + FULL_SCALE_LOG2;
            x_q     <= energy_q;
            k_q     <= 6'd63;
            step_q  <= '0;
            phase_q <= 1'b1;
          end else begin
            le_q <= log_v;
          end
        end
      end
      ST_GAIN: begin
        prod_q <= g * DB_PER_LOG2_Q16;
      end
      ST_BELOW: begin
        dep_q <= (below[18] || below == '0) ? 16'd0 : ONE_Q16;
        dq_q  <= dep_n[28:9];
      end
      ST_RECIP: begin
        dep_q <= dep_prod[39:24];
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_start_q <= start_q;
          out_end_q   <= end_q;
          out_score_q <= score_sum[16:1];
        end
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/windowed_rms_silence_run_detector.sv =====
// Top level: configuration registers, front end, run queue and scoring back end.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one interleaved audio sample per clock cycle while tready is high. Samples pass
// a four-stage front pipeline (square, window counters, threshold multiply, run tracking)
// that places each closed silent run in an eight-entry queue. The back end scores one run
// at a time: 16 steps of restoring division for the length score of runs shorter than
// twice the minimum, two passes of 6 normalization steps and 16 squaring steps of the
// shared 32x32 multiplier for the logarithms, and one reciprocal multiplication for the
// depth score. The sample input holds tready low only while four or more runs wait in
// the queue.
module windowed_rms_silence_run_detector
  import rmsd_pkg::*;
#(
  parameter int unsigned FRAME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned MAX_CHANNELS = 8,
  localparam int unsigned IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W       = ((2 * FRAME_BITS + 16 + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // slave stream: tdata = sample; tlast = last_of_buffer
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  input  wire logic              s_axis_tlast,
  // master stream: tdata = run_start_frame, run_end_frame, score
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned QDEPTH   = 8;
  localparam int unsigned QAW      = $clog2(QDEPTH);
  localparam int unsigned JOB_BITS = 2 * FRAME_BITS + ENERGY_BITS + COUNT_BITS;

  logic [3:0]  cfg_ch_q;
  logic [15:0] cfg_wf_q;
  logic [23:0] cfg_min_q;
  logic [30:0] cfg_thr_q;
  logic [15:0] cfg_db_q;
  logic        cfg_wr;
  reg_index_e  cfg_idx;

  logic                  push, pop, job_valid, accept, res_valid;
  logic [JOB_BITS-1:0]   job_in, job_out;
  logic [QAW:0]          level;
  logic [FRAME_BITS-1:0] res_start, res_end;
  logic [15:0]           res_score;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch_q  <= 4'd2;
      cfg_wf_q  <= 16'd480;
      cfg_min_q <= 24'd24000;
      cfg_thr_q <= 31'd107374;
      cfg_db_q  <= 16'hD800;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CHANNEL_COUNT: cfg_ch_q  <= pwdata[3:0];
        REG_WINDOW_FRAMES: cfg_wf_q  <= pwdata[15:0];
        REG_MIN_SILENCE:   cfg_min_q <= pwdata[23:0];
        REG_THRESH_POWER:  cfg_thr_q <= pwdata[30:0];
        REG_THRESH_DB:     cfg_db_q  <= pwdata[15:0];
        default:           cfg_ch_q  <= cfg_ch_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CHANNEL_COUNT: prdata = 32'(cfg_ch_q);
      REG_WINDOW_FRAMES: prdata = 32'(cfg_wf_q);
      REG_MIN_SILENCE:   prdata = 32'(cfg_min_q);
      REG_THRESH_POWER:  prdata = 32'(cfg_thr_q);
      REG_THRESH_DB:     prdata = 32'(cfg_db_q);
      default:           prdata = '0;
    endcase
  end

  // leave room for every item still in the front pipeline
  assign s_axis_tready = level <= (QAW + 1)'(QDEPTH - 5);
  assign accept        = s_axis_tvalid && s_axis_tready;

  rmsd_front #(
    .FRAME_BITS   (FRAME_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .channel_count_i   (cfg_ch_q),
    .window_frames_i   (cfg_wf_q),
    .threshold_power_i (cfg_thr_q),
    .in_valid_i        (accept),
    .in_sample_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last_i         (s_axis_tlast),
    .push_o            (push),
    .job_o             (job_in)
  );

  rmsd_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out),
    .level_o (level)
  );

  rmsd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .min_silence_i  (cfg_min_q),
    .threshold_db_i (cfg_db_q),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .pop_o          (pop),
    .out_valid_o    (res_valid),
    .out_ready_i    (m_axis_tready),
    .out_start_o    (res_start),
    .out_end_o      (res_end),
    .out_score_o    (res_score)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = OUT_W'({res_score, res_end, res_start});

endmodule

`default_nettype wire
